[hdl/best_rational_approximation_unit_macros.svh]
// assertion macros used by the back end of the rational approximation unit
`ifndef BEST_RATIONAL_APPROXIMATION_UNIT_MACROS_SVH
`define BEST_RATIONAL_APPROXIMATION_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BRA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define BRA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

[hdl/bra_pkg.sv]
// shared types and constants of the rational approximation unit
package bra_pkg;
   localparam int WORD_BITS = 64;
   localparam logic [WORD_BITS-1:0] WORD_LIM = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam int TERM_CAP = 64;
   localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
   localparam logic [62:0] MAX_DEN_RESET = 63'd1 << 30;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic        direct;
      logic        neg;
      logic        err;
      logic [63:0] mag;
      logic [63:0] d;
      logic [63:0] n;
   } bra_job_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } bra_div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } bra_div_rsp_type;
endpackage

[hdl/bra_channels.sv]
// channel interfaces: request, response and register write
interface bra_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;
   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

interface bra_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] numerator;
   logic [62:0]        denominator;
   logic               range_error;
   modport source (output valid, output numerator, output denominator, output range_error,
                   input ready);
   modport sink (input valid, input numerator, input denominator, input range_error,
                 output ready);
endinterface

interface bra_csr_if;
   logic        valid;
   logic        ready;
   logic [62:0] max_denominator;
   modport source (output valid, output max_denominator, input ready);
   modport sink (input valid, input max_denominator, output ready);
endinterface

[hdl/bra_front.sv]
// front end: unpacks the double, sorts out special cases, builds the dyadic pair
module bra_front (
   input  logic                 clock,
   input  logic                 reset,
   bra_req_if.sink              req,
   input  logic [62:0]          max_denominator,
   output bra_pkg::bra_job_type job,
   output logic                 job_valid,
   input  logic                 job_ready
);
   import bra_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_TZ, S_PUSH} state_type;

   state_type          state_ff, state_in;
   bra_job_type        job_ff, job_in;
   logic [52:0]        m_ff, m_in;
   logic signed [11:0] s_ff, s_in;
   logic               neg_ff, neg_in;
   logic [63:0]        ip_ff, ip_in;

   logic [10:0]        ef;
   logic [51:0]        frac;
   logic [52:0]        m;
   logic signed [11:0] e;
   logic [63:0]        ip;
   logic signed [11:0] neg_s;

   always_comb begin
      ef = req.value_bits[62:52];
      frac = req.value_bits[51:0];
      m = {(ef != 11'd0), frac};
      e = $signed({1'b0, (ef == 11'd0) ? 11'd1 : ef}) - 12'sd1023;
      if (e < 12'sd0) begin
         ip = 64'd0;
      end else if (e <= 12'sd52) begin
         ip = 64'(m) >> 6'(12'sd52 - e);
      end else begin
         ip = 64'(m) << 4'(e - 12'sd52);
      end
      neg_s = -s_ff;
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      m_in = m_ff;
      s_in = s_ff;
      neg_in = neg_ff;
      ip_in = ip_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               job_in = '0;
               job_in.direct = 1'b1;
               job_in.neg = req.value_bits[63];
               state_in = S_PUSH;
               if (ef == EXP_SPECIAL) begin
                  job_in.err = 1'b1;
                  if (frac != 52'd0) begin
                     job_in.neg = 1'b0;
                  end else begin
                     job_in.mag = WORD_LIM;
                  end
               end else if (m == 53'd0) begin
                  job_in.neg = 1'b0;
               end else if (e > 12'(WORD_BITS - 2)) begin
                  job_in.err = 1'b1;
                  job_in.mag = WORD_LIM;
               end else if (max_denominator <= 63'd1) begin
                  job_in.mag = ip;
               end else begin
                  m_in = m;
                  s_in = e - 12'sd52;
                  neg_in = req.value_bits[63];
                  ip_in = ip;
                  state_in = S_TZ;
               end
            end
         end
         S_TZ: begin
            // strip trailing zeros one bit a cycle
            if (!m_ff[0]) begin
               m_in = m_ff >> 1;
               s_in = s_ff + 12'sd1;
            end else begin
               job_in = '0;
               job_in.neg = neg_ff;
               state_in = S_PUSH;
               if (s_ff >= 12'sd0) begin
                  job_in.d = 64'(m_ff) << s_ff[5:0];
                  job_in.n = 64'd1;
               end else if (neg_s > 12'(WORD_BITS - 2)) begin
                  job_in.direct = 1'b1;
                  job_in.err = 1'b1;
                  job_in.mag = ip_ff;
               end else begin
                  job_in.d = 64'(m_ff);
                  job_in.n = 64'd1 << neg_s[5:0];
               end
            end
         end
         S_PUSH: begin
            if (job_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff <= job_in;
      m_ff <= m_in;
      s_ff <= s_in;
      neg_ff <= neg_in;
      ip_ff <= ip_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign job_valid = (state_ff == S_PUSH);
   assign job = job_ff;
endmodule

[hdl/bra_queue.sv]
// short job queue between front end and back end
module bra_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bra_pkg::bra_job_type in_job,
   input  logic                 in_valid,
   output logic                 in_ready,
   output bra_pkg::bra_job_type out_job,
   output logic                 out_valid,
   input  logic                 out_ready
);
   import bra_pkg::*;

   bra_job_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]       count_ff;
   logic                    push, pop;

   assign in_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end
endmodule

[hdl/bra_div.sv]
// restoring divider, one quotient bit a cycle
module bra_div (
   input  logic                     clock,
   input  logic                     reset,
   input  bra_pkg::bra_div_req_type div_req,
   output bra_pkg::bra_div_rsp_type div_rsp
);
   import bra_pkg::*;

   logic [63:0] q_ff, r_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [63:0] divisor_ff;
   logic [64:0] trial;
   logic [64:0] diff;

   assign trial = {r_ff, q_ff[63]};
   assign diff = trial - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 7'd1);
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 7'd64;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
      if (div_req.start) begin
         q_ff <= div_req.dividend;
         r_ff <= '0;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            r_ff <= diff[63:0];
            q_ff <= {q_ff[62:0], 1'b1};
         end else begin
            r_ff <= trial[63:0];
            q_ff <= {q_ff[62:0], 1'b0};
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = q_ff;
   assign div_rsp.remainder = r_ff;
endmodule

[hdl/bra_back.sv]
// back end: continued fraction sequencer with serial multiplier
module bra_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bra_pkg::bra_job_type     job,
   input  logic                     job_valid,
   output logic                     job_ready,
   input  logic [62:0]              max_denominator,
   output bra_pkg::bra_div_req_type div_req,
   input  bra_pkg::bra_div_rsp_type div_rsp,
   bra_rsp_if.source                rsp
);
   import bra_pkg::*;
`include "best_rational_approximation_unit_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE, S_TERM, S_DIV1, S_MUL1, S_CHECK, S_DIV2, S_MUL2, S_OUT
   } state_type;

   state_type    state_ff, state_in;
   logic [63:0]  h0_ff, h0_in, h1_ff, h1_in, k0_ff, k0_in, k1_ff, k1_in;
   logic [63:0]  d_ff, d_in, n_ff, n_in, a_ff, a_in;
   logic [6:0]   term_ff, term_in;
   logic [63:0]  mul_b_ff, mul_b_in, mh_ff, mh_in, acc_h_ff, acc_h_in;
   logic [127:0] mk_ff, mk_in, acc_k_ff, acc_k_in;
   logic         neg_ff, neg_in;
   logic [63:0]  num_ff, num_in;
   logic [62:0]  den_ff, den_in;
   logic         err_ff, err_in;

   logic [63:0]  hn, kn, fin_h, fin_k;
   logic [128:0] ksum;
   logic         reach;
   logic         last_x;
   logic         finish;

   always_comb begin
      hn = acc_h_ff + h0_ff;
      kn = acc_k_ff[63:0] + k0_ff;
      ksum = {1'b0, acc_k_ff} + 129'(k0_ff);
      // next denominator would reach the bound
      reach = (ksum >= 129'(max_denominator));
      last_x = ({div_rsp.quotient, 1'b0} >= {1'b0, a_ff}) || (k1_ff >= 64'(max_denominator));
      fin_h = (state_ff == S_MUL2) ? hn : h1_ff;
      fin_k = (state_ff == S_MUL2) ? kn : k1_ff;
   end

   always_comb begin
      state_in = state_ff;
      h0_in = h0_ff;
      h1_in = h1_ff;
      k0_in = k0_ff;
      k1_in = k1_ff;
      d_in = d_ff;
      n_in = n_ff;
      a_in = a_ff;
      term_in = term_ff;
      mul_b_in = mul_b_ff;
      mh_in = mh_ff;
      mk_in = mk_ff;
      acc_h_in = acc_h_ff;
      acc_k_in = acc_k_ff;
      neg_in = neg_ff;
      num_in = num_ff;
      den_in = den_ff;
      err_in = err_ff;
      div_req.start = 1'b0;
      div_req.dividend = d_ff;
      div_req.divisor = n_ff;
      finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               neg_in = job.neg;
               if (job.direct) begin
                  num_in = job.neg ? 64'd0 - job.mag : job.mag;
                  den_in = 63'd1;
                  err_in = job.err;
                  state_in = S_OUT;
               end else begin
                  h0_in = 64'd0;
                  h1_in = 64'd1;
                  k0_in = 64'd1;
                  k1_in = 64'd0;
                  d_in = job.d;
                  n_in = job.n;
                  term_in = '0;
                  state_in = S_TERM;
               end
            end
         end
         S_TERM: begin
            if (term_ff == 7'(TERM_CAP) || (term_ff != 7'd0 && n_ff == 64'd0)) begin
               finish = 1'b1;
            end else begin
               div_req.start = 1'b1;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               if (term_ff != 7'd0 && div_rsp.quotient == 64'd0) begin
                  finish = 1'b1;
               end else begin
                  a_in = div_rsp.quotient;
                  d_in = n_ff;
                  n_in = div_rsp.remainder;
                  mul_b_in = div_rsp.quotient;
                  mk_in = 128'(k1_ff);
                  mh_in = h1_ff;
                  acc_k_in = '0;
                  acc_h_in = '0;
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1, S_MUL2: begin
            if (mul_b_ff != 64'd0) begin
               if (mul_b_ff[0]) begin
                  acc_k_in = acc_k_ff + mk_ff;
                  acc_h_in = acc_h_ff + mh_ff;
               end
               mk_in = mk_ff << 1;
               mh_in = mh_ff << 1;
               mul_b_in = mul_b_ff >> 1;
            end else if (state_ff == S_MUL1) begin
               state_in = S_CHECK;
            end else begin
               finish = 1'b1;
            end
         end
         S_CHECK: begin
            if (!reach) begin
               h0_in = h1_ff;
               h1_in = hn;
               k0_in = k1_ff;
               k1_in = kn;
               term_in = term_ff + 7'd1;
               state_in = S_TERM;
            end else if (k1_ff != 64'd0 && 64'(max_denominator) > k0_ff) begin
               div_req.start = 1'b1;
               div_req.dividend = 64'(max_denominator) - k0_ff;
               div_req.divisor = k1_ff;
               state_in = S_DIV2;
            end else if (a_ff == 64'd0 || k1_ff >= 64'(max_denominator)) begin
               // truncated term is zero: next convergent is the previous one
               mul_b_in = 64'd0;
               acc_k_in = '0;
               acc_h_in = '0;
               state_in = S_MUL2;
            end else begin
               finish = 1'b1;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               if (last_x) begin
                  mul_b_in = div_rsp.quotient;
                  mk_in = 128'(k1_ff);
                  mh_in = h1_ff;
                  acc_k_in = '0;
                  acc_h_in = '0;
                  state_in = S_MUL2;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         num_in = neg_ff ? 64'd0 - fin_h : fin_h;
         den_in = fin_k[62:0];
         err_in = 1'b0;
         state_in = S_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         term_ff <= '0;
      end else begin
         state_ff <= state_in;
         term_ff <= term_in;
      end
      h0_ff <= h0_in;
      h1_ff <= h1_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      d_ff <= d_in;
      n_ff <= n_in;
      a_ff <= a_in;
      mul_b_ff <= mul_b_in;
      mh_ff <= mh_in;
      mk_ff <= mk_in;
      acc_h_ff <= acc_h_in;
      acc_k_ff <= acc_k_in;
      neg_ff <= neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
      err_ff <= err_in;
   end

   assign job_ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.numerator = num_ff;
   assign rsp.denominator = den_ff;
   assign rsp.range_error = err_ff;

   `BRA_ASSERT(a_rsp_den, rsp.valid |-> (rsp.denominator != 63'd0), "zero denominator")
   `BRA_ASSERT(a_term_cap, (term_ff <= 7'(TERM_CAP)), "term count past cap")
   `BRA_ASSERT(a_div_wait, div_rsp.done |-> (state_ff == S_DIV1 || state_ff == S_DIV2), "divider result outside a wait state")
   `BRA_ASSERT_NEXT(a_div_latency, div_req.start, !div_rsp.done, "divider finished too early")
endmodule

[hdl/best_rational_approximation_unit.sv]
// flow: the front end unpacks the request, then each continued fraction term takes a divide
// and a serial shift-add multiply, at most 64 terms and one final step
// special values and integer truncation bypass the divider and multiplier and go straight to the output state
// the front end takes the next transaction while the back end works, via a 2-entry queue
// synchronous active-high reset; max_denominator resets to 2^30
module best_rational_approximation_unit (
   input  logic clock,
   input  logic reset,
   bra_req_if.sink   req_chan,
   bra_rsp_if.source rsp_chan,
   bra_csr_if.sink   csr_chan
);
   import bra_pkg::*;

   logic [62:0]     max_den_ff;
   bra_job_type     front_job, queue_job;
   logic            front_valid, front_ready, queue_valid, queue_ready;
   bra_div_req_type div_req;
   bra_div_rsp_type div_rsp;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_den_ff <= MAX_DEN_RESET;
      end else if (csr_chan.valid) begin
         max_den_ff <= csr_chan.max_denominator;
      end
   end

   bra_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .max_denominator(max_den_ff),
      .job            (front_job),
      .job_valid      (front_valid),
      .job_ready      (front_ready)
   );

   bra_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_job   (front_job),
      .in_valid (front_valid),
      .in_ready (front_ready),
      .out_job  (queue_job),
      .out_valid(queue_valid),
      .out_ready(queue_ready)
   );

   bra_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   bra_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job            (queue_job),
      .job_valid      (queue_valid),
      .job_ready      (queue_ready),
      .max_denominator(max_den_ff),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp            (rsp_chan)
   );
endmodule
